// ===== src/bfs_pkg.sv =====
// Shared types, widths and constants of the 3x3 box-filter smoother.
// Used by every module of the block; no dependencies.
package bfs_pkg;

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int FW_W     = 11;
    localparam int FH_W     = 16;

    // Default line store depth and register reset values
    localparam int           MAX_WIDTH_DEF    = 1024;
    localparam logic [FW_W-1:0] FW_RESET      = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET      = 16'd1024;
    localparam int           MIN_SIZE         = 3;

    // Register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Window sum and divide-by-nine by reciprocal multiplication
    localparam int SUM_W       = 20;
    localparam int MAG_W       = 19;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_9 = 18'd233017;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_EFF,
        ST_MUL,
        ST_DIV,
        ST_RUN
    } seq_state_t;

    // Per-item control decided at acceptance
    typedef struct packed {
        logic valid;
        logic is_sample;
        logic emit;
        logic use_mean;
        logic frame_end;
    } item_ctl_t;

endpackage

// ===== src/bfs_line_ram.sv =====
// One line store: single-port-write, single-port-read synchronous memory
// with a registered read. Depends on bfs_pkg.
module bfs_line_ram #(
    parameter int DEPTH  = bfs_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(bfs_pkg::MAX_WIDTH_DEF)
) (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [bfs_pkg::SAMPLE_W-1:0] rd_data,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [bfs_pkg::SAMPLE_W-1:0] wr_data
);

    logic signed [bfs_pkg::SAMPLE_W-1:0] mem_array [DEPTH];
    logic signed [bfs_pkg::SAMPLE_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/bfs_seq.sv =====
// Position sequencer: input and output raster counters, line store clear
// pass, size recompute after configuration and a bit-serial divider.
// Depends on bfs_pkg.
module bfs_seq #(
    parameter int MAX_WIDTH = bfs_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(bfs_pkg::MAX_WIDTH_DEF),
    parameter int WID_W     = $clog2(bfs_pkg::MAX_WIDTH_DEF + 1),
    parameter int POS_W     = $clog2(bfs_pkg::MAX_WIDTH_DEF + 1) + bfs_pkg::FH_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr,
    input  logic [bfs_pkg::FW_W-1:0]    fw,
    input  logic [bfs_pkg::FH_W-1:0]    fh,
    input  logic                        accept,
    input  logic                        op,
    output logic                        busy,
    output logic [COL_W-1:0]            rd_col,
    output bfs_pkg::item_ctl_t          ctl0,
    output logic                        clr_en,
    output logic [COL_W-1:0]            clr_addr
);

    localparam int CNT_W = $clog2(POS_W + 1);
    localparam int FH_W  = bfs_pkg::FH_W;

    bfs_pkg::seq_state_t state_reg, state_next;

    logic [COL_W-1:0] clr_cnt_reg;
    logic [WID_W-1:0] w_reg;
    logic [FH_W-1:0]  h_reg;
    logic [COL_W-1:0] col_raw_reg, col_reg;
    logic [FH_W-1:0]  row_raw_reg, row_reg;
    logic [POS_W-1:0] n_reg, total_m1_reg, pos_reg, orow_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [WID_W-1:0] div_rem_reg;
    logic [POS_W-1:0] div_quot_reg;
    logic [CNT_W-1:0] div_cnt_reg;

    // Effective sizes from the raw registers
    logic [31:0]      fw_ext;
    logic [WID_W-1:0] eff_w;
    logic [FH_W-1:0]  eff_h;

    assign fw_ext = 32'(fw);
    always_comb begin
        if (fw_ext < 32'(bfs_pkg::MIN_SIZE)) begin
            eff_w = WID_W'(bfs_pkg::MIN_SIZE);
        end else if (fw_ext > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(fw_ext);
        end
        eff_h = (fh < FH_W'(bfs_pkg::MIN_SIZE)) ? FH_W'(bfs_pkg::MIN_SIZE) : fh;
    end

    // Wrapped input position and frame size products
    logic [COL_W-1:0] col_wrap;
    logic [FH_W-1:0]  row_wrap;
    logic [POS_W-1:0] n_calc, total_calc;

    assign col_wrap   = (WID_W'(col_raw_reg) >= w_reg) ? '0 : col_raw_reg;
    assign row_wrap   = (row_raw_reg >= h_reg) ? '0 : row_raw_reg;
    assign n_calc     = POS_W'(row_wrap) * POS_W'(w_reg) + POS_W'(col_wrap);
    assign total_calc = POS_W'(h_reg) * POS_W'(w_reg);

    // One restoring divide step of out_position by the width
    logic [WID_W:0]   rem_sh, rem_sub;
    logic             div_ge;
    logic [WID_W-1:0] rem_new;
    logic [POS_W-1:0] quot_new;

    assign rem_sh   = {div_rem_reg, div_quot_reg[POS_W-1]};
    assign div_ge   = rem_sh >= {1'b0, w_reg};
    assign rem_sub  = rem_sh - {1'b0, w_reg};
    assign rem_new  = div_ge ? rem_sub[WID_W-1:0] : rem_sh[WID_W-1:0];
    assign quot_new = {div_quot_reg[POS_W-2:0], div_ge};

    // Per-item decisions
    logic [POS_W-1:0] w_pos, h_pos;
    logic             draining, is_sample, emit, interior, frame_end;
    logic             col_last, row_last, ocol_last;

    assign w_pos     = POS_W'(w_reg);
    assign h_pos     = POS_W'(h_reg);
    assign draining  = pos_reg > n_reg;
    assign is_sample = (op == bfs_pkg::OP_SAMPLE);
    assign emit      = draining || (is_sample && (n_reg >= w_pos + POS_W'(1)));
    assign interior  = (orow_reg != '0) && (orow_reg < h_pos - POS_W'(1))
                    && (ocol_reg != '0) && (WID_W'(ocol_reg) < w_reg - WID_W'(1));
    assign frame_end = pos_reg >= total_m1_reg;
    assign col_last  = (WID_W'(col_reg) + WID_W'(1)) >= w_reg;
    assign row_last  = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_reg};
    assign ocol_last = (WID_W'(ocol_reg) + WID_W'(1)) >= w_reg;

    always_comb begin
        ctl0.valid     = accept;
        ctl0.is_sample = is_sample;
        ctl0.emit      = emit;
        ctl0.use_mean  = is_sample && !draining && interior;
        ctl0.frame_end = frame_end;
    end

    assign rd_col   = col_reg;
    assign clr_addr = clr_cnt_reg;

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        busy       = 1'b1;
        clr_en     = 1'b0;
        unique case (state_reg)
            bfs_pkg::ST_CLEAR: begin
                clr_en = 1'b1;
                if (clr_cnt_reg == COL_W'(MAX_WIDTH - 1)) begin
                    state_next = bfs_pkg::ST_EFF;
                end
            end
            bfs_pkg::ST_EFF: begin
                state_next = bfs_pkg::ST_MUL;
            end
            bfs_pkg::ST_MUL: begin
                state_next = bfs_pkg::ST_DIV;
            end
            bfs_pkg::ST_DIV: begin
                if (div_cnt_reg == CNT_W'(1)) begin
                    state_next = bfs_pkg::ST_RUN;
                end
            end
            bfs_pkg::ST_RUN: begin
                busy = 1'b0;
            end
            default: begin
                state_next = bfs_pkg::ST_EFF;
            end
        endcase
        // A register write outside the clear pass restarts the recompute
        if (cfg_wr && state_reg != bfs_pkg::ST_CLEAR) begin
            state_next = bfs_pkg::ST_EFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Counters and recompute datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            w_reg        <= WID_W'(MAX_WIDTH);
            h_reg        <= bfs_pkg::FH_RESET;
            col_raw_reg  <= '0;
            col_reg      <= '0;
            row_raw_reg  <= '0;
            row_reg      <= '0;
            n_reg        <= '0;
            total_m1_reg <= '0;
            pos_reg      <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            div_rem_reg  <= '0;
            div_quot_reg <= '0;
            div_cnt_reg  <= '0;
        end else begin
            unique case (state_reg)
                bfs_pkg::ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
                end
                bfs_pkg::ST_EFF: begin
                    w_reg <= eff_w;
                    h_reg <= eff_h;
                end
                bfs_pkg::ST_MUL: begin
                    col_reg      <= col_wrap;
                    row_reg      <= row_wrap;
                    n_reg        <= n_calc;
                    total_m1_reg <= total_calc - POS_W'(1);
                    div_rem_reg  <= '0;
                    div_quot_reg <= pos_reg;
                    div_cnt_reg  <= CNT_W'(POS_W);
                end
                bfs_pkg::ST_DIV: begin
                    div_rem_reg  <= rem_new;
                    div_quot_reg <= quot_new;
                    div_cnt_reg  <= div_cnt_reg - CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(1)) begin
                        orow_reg <= quot_new;
                        ocol_reg <= COL_W'(rem_new);
                    end
                end
                bfs_pkg::ST_RUN: begin
                    if (accept) begin
                        // Any item makes the wrapped input position stick
                        col_raw_reg <= col_reg;
                        row_raw_reg <= row_reg;
                        if (is_sample) begin
                            if (col_last) begin
                                col_reg     <= '0;
                                col_raw_reg <= '0;
                                if (row_last) begin
                                    row_reg     <= '0;
                                    row_raw_reg <= '0;
                                    n_reg       <= '0;
                                end else begin
                                    row_reg     <= row_reg + FH_W'(1);
                                    row_raw_reg <= row_reg + FH_W'(1);
                                    n_reg       <= n_reg + POS_W'(1);
                                end
                            end else begin
                                col_reg     <= col_reg + COL_W'(1);
                                col_raw_reg <= col_reg + COL_W'(1);
                                n_reg       <= n_reg + POS_W'(1);
                            end
                        end
                        // Advance the output position on each result
                        if (emit) begin
                            if (frame_end) begin
                                pos_reg  <= '0;
                                orow_reg <= '0;
                                ocol_reg <= '0;
                            end else begin
                                pos_reg <= pos_reg + POS_W'(1);
                                if (ocol_last) begin
                                    ocol_reg <= '0;
                                    orow_reg <= orow_reg + POS_W'(1);
                                end else begin
                                    ocol_reg <= ocol_reg + COL_W'(1);
                                end
                            end
                        end
                    end
                end
                default: begin
                    clr_cnt_reg <= '0;
                end
            endcase
        end
    end

    // Checks on the sequencer
    a_accept_run: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> state_reg == bfs_pkg::ST_RUN)
        else $error("item accepted outside run state");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bfs_pkg::ST_RUN |-> (WID_W'(col_reg) < w_reg && row_reg < h_reg))
        else $error("input position outside frame");

    a_index_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bfs_pkg::ST_RUN
        |-> n_reg == POS_W'(row_reg) * POS_W'(w_reg) + POS_W'(col_reg))
        else $error("raster index out of step with row and column");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && state_reg != bfs_pkg::ST_CLEAR) |=> state_reg == bfs_pkg::ST_EFF)
        else $error("register write did not restart recompute");

endmodule

// ===== src/bfs_window.sv =====
// Window datapath: line store write-back, 3x3 window registers, nine-way
// sum, divide by nine by reciprocal multiplication and the output register.
// Depends on bfs_pkg.
module bfs_window #(
    parameter int COL_W = $clog2(bfs_pkg::MAX_WIDTH_DEF)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  bfs_pkg::item_ctl_t                  ctl0,
    input  logic [COL_W-1:0]                    col0,
    input  logic signed [bfs_pkg::SAMPLE_W-1:0] sample0,
    input  logic signed [bfs_pkg::SAMPLE_W-1:0] top_rd,
    input  logic signed [bfs_pkg::SAMPLE_W-1:0] mid_rd,
    output logic                                wb_en,
    output logic [COL_W-1:0]                    wb_col,
    output logic signed [bfs_pkg::SAMPLE_W-1:0] wb_sample,
    output logic                                out_valid,
    output logic [bfs_pkg::SAMPLE_W-1:0]        out_data,
    output logic                                out_last
);

    localparam int SW = bfs_pkg::SAMPLE_W;

    bfs_pkg::item_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic signed [SW-1:0] s1_sample_reg;
    logic signed [SW-1:0] win_reg [9];
    logic signed [bfs_pkg::SUM_W-1:0] sum_reg;
    logic [bfs_pkg::PROD_W-1:0]       prod_reg;
    logic                             neg_reg;
    logic                             out_valid_reg, out_last_reg;
    logic [SW-1:0]                    out_data_reg;

    logic s1_shift;
    assign s1_shift  = adv && s1_ctl_reg.valid && s1_ctl_reg.is_sample;
    assign wb_en     = s1_shift;
    assign wb_col    = s1_col_reg;
    assign wb_sample = s1_sample_reg;

    // Stage control and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            s4_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_ctl_reg    <= ctl0;
            s2_ctl_reg    <= s1_ctl_reg;
            s3_ctl_reg    <= s2_ctl_reg;
            s4_ctl_reg    <= s3_ctl_reg;
            out_valid_reg <= s4_ctl_reg.valid && s4_ctl_reg.emit;
        end
    end

    // Shift the window on each sample item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_shift) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3 + 0] <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= top_rd;
            win_reg[5] <= mid_rd;
            win_reg[8] <= s1_sample_reg;
        end
    end

    // Sum the window, split sign and magnitude
    logic signed [bfs_pkg::SUM_W-1:0] sum_acc;
    logic signed [bfs_pkg::SUM_W-1:0] sum_abs;
    always_comb begin
        sum_acc = '0;
        for (int k = 0; k < 9; k++) begin
            sum_acc = sum_acc + bfs_pkg::SUM_W'(win_reg[k]);
        end
        sum_abs = sum_reg[bfs_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    end

    // Quotient and sign for the result
    logic [SW-1:0] quot;
    logic [SW-1:0] mean;
    assign quot = prod_reg[bfs_pkg::RECIP_SHIFT + SW - 1 : bfs_pkg::RECIP_SHIFT];
    assign mean = neg_reg ? (SW'(0) - quot) : quot;

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_col_reg    <= col0;
            s1_sample_reg <= sample0;
            sum_reg       <= sum_acc;
            neg_reg       <= sum_reg[bfs_pkg::SUM_W-1];
            prod_reg      <= bfs_pkg::PROD_W'(sum_abs[bfs_pkg::MAG_W-1:0])
                           * bfs_pkg::PROD_W'(bfs_pkg::RECIP_9);
            out_data_reg  <= s4_ctl_reg.use_mean ? mean : '0;
            out_last_reg  <= s4_ctl_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/box_filter_3x3_smoother.sv =====
// Top level of the 3x3 box-filter smoother: configuration registers,
// stream handshake and the two line stores. Depends on bfs_pkg and the
// bfs_line_ram, bfs_seq and bfs_window modules.
//
// Usage: samples of a raster frame enter on the s_ stream in row-major
// order, s_tuser = 0 with the signed sample in s_tdata; s_tuser = 1 is a
// flush tick that drains one pending border output at the end of a frame.
// Results leave on the m_ stream, m_tdata the 3x3 mean truncated toward
// zero (0 on border rows and columns), m_tlast on the last output of a
// frame. Outputs trail the input by one frame line plus one sample.
// Throughput is one item per cycle unless held by m_tready or a recompute; a
// result is registered through line store read, window update, sum,
// reciprocal multiply and output register. When m_tready is low with a
// result held, the whole pipeline holds and s_tready drops. After reset
// both line stores are cleared, one entry per cycle, then the sizes are
// set up; s_tready stays low meanwhile. Each register write sets s_tready
// low while the frame sizes and output position are recomputed
// (bit-serial divide of the position).
// Registers: frame_width at byte address 0, frame_height at 4.
module box_filter_3x3_smoother #(
    parameter int MAX_WIDTH = bfs_pkg::MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic        s_tuser,   // [0] operation
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] smoothed_value
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int POS_W = WID_W + bfs_pkg::FH_W;

    logic [bfs_pkg::FW_W-1:0] fw_reg;
    logic [bfs_pkg::FH_W-1:0] fh_reg;
    logic                     cfg_wr;

    // Register writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= bfs_pkg::FW_RESET;
            fh_reg <= bfs_pkg::FH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                bfs_pkg::REG_FRAME_WIDTH:  fw_reg <= pwdata[bfs_pkg::FW_W-1:0];
                bfs_pkg::REG_FRAME_HEIGHT: fh_reg <= pwdata[bfs_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bfs_pkg::REG_FRAME_WIDTH:  prdata = 32'(fw_reg);
            bfs_pkg::REG_FRAME_HEIGHT: prdata = 32'(fh_reg);
            default:                   prdata = '0;
        endcase
    end

    // Handshake: the pipeline moves whenever the output register is free or its result is taken
    logic adv, busy, accept;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !busy;
    assign accept   = s_tvalid && s_tready;

    bfs_pkg::item_ctl_t ctl0;
    logic [COL_W-1:0]   rd_col, clr_addr, wb_col;
    logic               clr_en, wb_en;
    logic signed [bfs_pkg::SAMPLE_W-1:0] top_rd, mid_rd, wb_sample;

    bfs_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .WID_W     (WID_W),
        .POS_W     (POS_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .fw       (fw_reg),
        .fh       (fh_reg),
        .accept   (accept),
        .op       (s_tuser),
        .busy     (busy),
        .rd_col   (rd_col),
        .ctl0     (ctl0),
        .clr_en   (clr_en),
        .clr_addr (clr_addr)
    );

    // Upper store takes the old middle row, middle store the new sample
    logic [COL_W-1:0] ram_wr_addr;
    logic             ram_wr_en;
    logic signed [bfs_pkg::SAMPLE_W-1:0] upper_wd, middle_wd;

    assign ram_wr_en   = clr_en || wb_en;
    assign ram_wr_addr = clr_en ? clr_addr : wb_col;
    assign upper_wd    = clr_en ? '0 : mid_rd;
    assign middle_wd   = clr_en ? '0 : wb_sample;

    bfs_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_upper (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .rd_data (top_rd),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (upper_wd)
    );

    bfs_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_middle (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .rd_data (mid_rd),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (middle_wd)
    );

    bfs_window #(
        .COL_W (COL_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .ctl0      (ctl0),
        .col0      (rd_col),
        .sample0   (s_tdata),
        .top_rd    (top_rd),
        .mid_rd    (mid_rd),
        .wb_en     (wb_en),
        .wb_col    (wb_col),
        .wb_sample (wb_sample),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== test/box_filter_3x3_smoother_tb.sv =====
// Self-checking testbench for the 3x3 box-filter smoother: raster frames in, window means out.
// Depends on bfs_pkg and the box_filter_3x3_smoother top level; a class predicts and checks
// every result while plain tasks drive the stream and configuration ports.
module box_filter_3x3_smoother_tb;
    import bfs_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int FW_MASK      = (1 << FW_W) - 1;
    localparam int FH_MASK      = (1 << FH_W) - 1;
    localparam int SETTLE       = 12;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 950;
    localparam int TIMEOUT      = 3000000;
    localparam int PRINT_CAP    = 40;

    localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;

    typedef enum int {
        STYLE_FULL,
        STYLE_EXTREME,
        STYLE_SMALL
    } frame_style_t;

    typedef struct packed {
        logic [15:0] mean;
        logic        frame_end;
    } smoothed_item_t;

    // Tracks the filter state, predicts each output and compares it with the block
    class mean_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        logic signed [15:0] upper_line [MAX_W];
        logic signed [15:0] middle_line [MAX_W];
        logic signed [15:0] window [9];
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_pos;
        smoothed_item_t expected_means [$];
        int errors;
        int checked;

        function new();
            int k;
            width_reg = 32'(FW_RESET);
            height_reg = 32'(FH_RESET);
            for (k = 0; k < MAX_W; k++) begin
                upper_line[k] = '0;
                middle_line[k] = '0;
            end
            for (k = 0; k < 9; k++) window[k] = '0;
            in_col = 0;
            in_row = 0;
            out_pos = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_SIZE) return MIN_SIZE;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
        endfunction

        function void write_reg(logic idx, int unsigned value);
            if (idx == REG_FRAME_WIDTH) width_reg = value & FW_MASK;
            else height_reg = value & FH_MASK;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        // Emit the output at the current output position and advance it
        function void queue_mean(bit use_window, int unsigned w, int unsigned h);
            int unsigned total;
            int unsigned pos;
            int unsigned row_o;
            int unsigned col_o;
            int sum;
            int k;
            smoothed_item_t res;
            total = w * h;
            pos = out_pos;
            row_o = pos / w;
            col_o = pos % w;
            res.mean = '0;
            if (use_window && row_o > 0 && row_o < h - 1 && col_o > 0 && col_o < w - 1) begin
                sum = 0;
                for (k = 0; k < 9; k++) sum += int'(window[k]);
                res.mean = 16'(sum / 9);
            end
            res.frame_end = (pos >= total - 1);
            out_pos = res.frame_end ? 0 : pos + 1;
            expected_means.push_back(res);
        endfunction

        // Note an accepted item; returns 1 when it causes a result
        function bit note_input(logic op, logic [15:0] value);
            int unsigned w;
            int unsigned h;
            int unsigned n;
            int unsigned c;
            int r;
            logic signed [15:0] top_s;
            logic signed [15:0] mid_s;
            bit draining;
            bit produced;
            w = eff_width();
            h = eff_height();
            if (in_col >= w) in_col = 0;
            if (in_row >= h) in_row = 0;
            n = in_row * w + in_col;
            draining = (out_pos > n);
            produced = 1'b0;
            if (op == OP_FLUSH) begin
                if (draining) begin
                    queue_mean(1'b0, w, h);
                    produced = 1'b1;
                end
                return produced;
            end
            // Rotate the line stores and shift the window one column left
            c = in_col;
            top_s = upper_line[c];
            mid_s = middle_line[c];
            upper_line[c] = mid_s;
            middle_line[c] = value;
            for (r = 0; r < 3; r++) begin
                window[r * 3 + 0] = window[r * 3 + 1];
                window[r * 3 + 1] = window[r * 3 + 2];
            end
            window[2] = top_s;
            window[5] = mid_s;
            window[8] = value;
            if (draining) begin
                queue_mean(1'b0, w, h);
                produced = 1'b1;
            end else if (n >= w + 1) begin
                queue_mean(1'b1, w, h);
                produced = 1'b1;
            end
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            return produced;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [15:0] mean, logic frame_end);
            smoothed_item_t want;
            checked++;
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("output %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_means.pop_front();
            if (mean !== want.mean)
                report_mismatch($sformatf("output %0d mean %0d, want %0d", checked,
                                          $signed(mean), $signed(want.mean)));
            if (frame_end !== want.frame_end)
                report_mismatch($sformatf("output %0d frame end %b, want %b", checked,
                                          frame_end, want.frame_end));
        endtask

        task report_leftover();
            report_mismatch($sformatf("%0d outputs never arrived", expected_means.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] sample_value
    logic        s_tuser;    // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] smoothed_value
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mean_scoreboard board;
    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    bit paused_once;
    bit held_once;
    int random_items;
    int items_sent;
    int config_writes;
    int phases;

    box_filter_3x3_smoother dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abandon a hung run
    initial begin
        #(TIMEOUT);
        $display("box_filter_3x3_smoother_tb: done, errors");
        $finish;
    end

    // Drive the result side: random back-pressure or steady readiness, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (receiver_idles) begin
                m_tready = ($urandom_range(0, 99) >= 16);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Check each accepted output item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
    end

    // Offer one item, with random idle cycles ahead of it, and note it once accepted
    task automatic send_item(input logic op, input logic [15:0] value, output bit produced);
        while (sender_idles && $urandom_range(0, 99) < 16) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata = 16'($urandom);
            s_tuser = 1'($urandom_range(0, 1));
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = value;
        s_tuser = op;
        do @(posedge aclk); while (!s_tready);
        produced = board.note_input(op, value);
        items_sent++;
    endtask

    // Lower valid and wait for every expected output or DRAIN_LIMIT, then let the pipe empty
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, value);
        config_writes++;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Send a random-phase item; count it and fire the quiet stretch and pressure points
    task automatic send_counted(input logic op, input logic [15:0] value);
        bit produced;
        send_item(op, value, produced);
        if (op == OP_SAMPLE || produced) random_items++;
        sender_idles = !(random_items >= 400 && random_items < 550);
        receiver_idles = sender_idles;
        if (!paused_once && random_items >= 250) begin
            paused_once = 1'b1;
            @(negedge aclk);
            s_tvalid = 1'b0;
            while (board.pending() != 0) @(posedge aclk);
        end
        if (!held_once && random_items >= 650) begin
            held_once = 1'b1;
            hold_request = 1'b1;
        end
    endtask

    function automatic logic [15:0] pick_sample(frame_style_t style);
        case (style)
            STYLE_EXTREME: begin
                return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            end
            STYLE_SMALL: begin
                return 16'($signed($urandom_range(0, 16)) - 8);
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // Pick new frame sizes, out-of-range values now and then, and write one or both of them
    task automatic configure_sizes();
        int unsigned width_val;
        int unsigned height_val;
        int unsigned pick;
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) width_val = $urandom_range(0, 2);
        else if (r < 14) width_val = MIN_SIZE;
        else if (r < 24) width_val = $urandom_range(17, 48);
        else width_val = $urandom_range(4, 16);
        r = $urandom_range(0, 99);
        if (r < 8) height_val = $urandom_range(0, 2);
        else if (r < 18) height_val = $urandom_range(9, 12);
        else height_val = $urandom_range(3, 8);
        // Upper bits beyond each register are don't-care
        if ($urandom_range(0, 3) == 0) begin
            width_val |= $urandom << FH_W;
            height_val |= $urandom << FH_W;
        end
        pick = (phases == 0) ? 0 : $urandom_range(0, 99);
        if (pick < 70 || pick >= 85) write_register(REG_FRAME_WIDTH, width_val);
        if (pick < 85) write_register(REG_FRAME_HEIGHT, height_val);
    endtask

    initial begin
        bit produced;
        int unsigned w;
        int unsigned h;
        int unsigned tail;
        frame_style_t style;

        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_SAMPLE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_request = 1'b0;
        paused_once = 1'b0;
        held_once = 1'b0;
        random_items = 0;
        items_sent = 0;
        config_writes = 0;
        phases = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Default sizes: a few samples and a flush with nothing to drain
        repeat (3) send_item(OP_SAMPLE, 16'($urandom), produced);
        send_item(OP_FLUSH, 16'($urandom), produced);
        wait_drained();

        // Undersized registers act as 3x3; the column position wraps mid-frame
        write_register(REG_FRAME_WIDTH, 0);
        write_register(REG_FRAME_HEIGHT, 1);
        repeat (9) send_item(OP_SAMPLE, SAMPLE_MAX, produced);
        repeat (2) send_item(OP_FLUSH, 16'($urandom), produced);
        // Next frame's early samples drain the rest of the border
        repeat (9) send_item(OP_SAMPLE, SAMPLE_MIN, produced);
        repeat (2) send_item(OP_FLUSH, 16'($urandom), produced);
        wait_drained();

        // Oversized width clamps to the line store depth; tallest height
        write_register(REG_FRAME_WIDTH, FW_MASK);
        write_register(REG_FRAME_HEIGHT, FH_MASK);
        send_item(OP_SAMPLE, 16'($urandom), produced);

        // Random phases: mostly whole frames with a drain tail, some loose noise
        while (random_items < RANDOM_ITEMS) begin
            wait_drained();
            configure_sizes();
            phases++;
            w = board.eff_width();
            h = board.eff_height();
            if ($urandom_range(0, 99) < 80) begin
                repeat ($urandom_range(1, 3)) begin
                    // Stop once the item budget is spent
                    if (random_items >= RANDOM_ITEMS) break;
                    style = frame_style_t'($urandom_range(0, 2));
                    repeat (w * h) begin
                        if (random_items >= RANDOM_ITEMS) break;
                        send_counted(OP_SAMPLE, pick_sample(style));
                    end
                    tail = ($urandom_range(0, 3) == 0) ? w + 1 : $urandom_range(0, w + 3);
                    repeat (tail) send_counted(OP_FLUSH, 16'($urandom));
                end
            end else begin
                repeat ($urandom_range(5, 60)) begin
                    if ($urandom_range(0, 99) < 30) send_counted(OP_FLUSH, 16'($urandom));
                    else send_counted(OP_SAMPLE, 16'($urandom));
                end
            end
        end

        wait_drained();
        if (board.pending() != 0) board.report_leftover();

        $display("Sent %0d items over %0d random phases with %0d register writes;",
                 items_sent, phases, config_writes);
        $display("checked %0d output items, border drains and frame ends included.",
                 board.checked);
        if (board.errors == 0) begin
            $display("box_filter_3x3_smoother_tb: done, clean");
        end else begin
            $display("box_filter_3x3_smoother_tb: done, errors");
        end
        $finish;
    end

endmodule
